FILE: rtl/sgba_pkg.sv
// Shared constants and types for the sorted group-by aggregator with having filter.
// No dependencies; every other file in rtl/ refers to it by scoped names.
package sgba_pkg;

   localparam int DATA_WIDTH_DEF  = 32;
   localparam int QUEUE_DEPTH_DEF = 4;

   // port payload widths (fixed by the field list)
   localparam int FIELD_W     = 32;
   localparam int REQ_TDATA_W = 96;
   localparam int RSP_TDATA_W = 64;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int FUNC_W      = 3;

   // configuration register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_HAVING_FUNC = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_HAVING_OP   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_THRESHOLD   = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_RETURN_FUNC = 2'd3;

   // aggregate function codes
   localparam logic [FUNC_W-1:0] FN_AVG   = 3'd0;
   localparam logic [FUNC_W-1:0] FN_SUM   = 3'd1;
   localparam logic [FUNC_W-1:0] FN_MAX   = 3'd2;
   localparam logic [FUNC_W-1:0] FN_MIN   = 3'd3;
   localparam logic [FUNC_W-1:0] FN_COUNT = 3'd4;

   // comparison codes
   localparam logic [FUNC_W-1:0] OP_LT = 3'd0;
   localparam logic [FUNC_W-1:0] OP_GT = 3'd1;
   localparam logic [FUNC_W-1:0] OP_LE = 3'd2;
   localparam logic [FUNC_W-1:0] OP_GE = 3'd3;
   localparam logic [FUNC_W-1:0] OP_EQ = 3'd4;
   localparam logic [FUNC_W-1:0] OP_NE = 3'd5;

   // group record layout: one data word per field, row-end flag on top
   localparam int REC_KEY    = 0;
   localparam int REC_CNT    = 1;
   localparam int REC_HSUM   = 2;
   localparam int REC_HMAX   = 3;
   localparam int REC_HMIN   = 4;
   localparam int REC_RSUM   = 5;
   localparam int REC_RMAX   = 6;
   localparam int REC_RMIN   = 7;
   localparam int REC_FIELDS = 8;

   typedef struct packed {
      logic [FUNC_W-1:0] having_func;
      logic [FUNC_W-1:0] having_op;
      logic [FUNC_W-1:0] return_func;
   } cfg_type;

   typedef enum logic [5:0] {
      BK_IDLE = 6'b000001,
      BK_HDIV = 6'b000010,
      BK_TEST = 6'b000100,
      BK_RDIV = 6'b001000,
      BK_OUT  = 6'b010000,
      BK_OUT2 = 6'b100000
   } back_state_type;

endpackage

FILE: rtl/sgba_front.sv
// Front end: accepts sorted rows, keeps the open group's count/sum/max/min,
// and pushes one closed-group record per cycle into the queue while it is not full. Uses sgba_pkg.
module sgba_front #(
   parameter int DATA_WIDTH = sgba_pkg::DATA_WIDTH_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          row_valid,
   output logic                                          row_ready,
   input  logic [DATA_WIDTH-1:0]                         row_key,
   input  logic [DATA_WIDTH-1:0]                         row_hv,
   input  logic [DATA_WIDTH-1:0]                         row_rv,
   input  logic                                          row_last,
   output logic                                          push,
   output logic [sgba_pkg::REC_FIELDS*DATA_WIDTH:0]      push_rec,
   input  logic                                          q_full
);

   localparam int F = sgba_pkg::REC_FIELDS;
   localparam logic [DATA_WIDTH-1:0] SMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

   logic                         started_ff, started_in;
   logic                         close_pend_ff, close_pend_in;
   logic [F-1:0][DATA_WIDTH-1:0] grp_ff, grp_in, upd, opn;
   logic                         fire, same;

   assign row_ready = !close_pend_ff && !q_full;
   assign fire      = row_valid && row_ready;
   assign same      = started_ff && (row_key == grp_ff[sgba_pkg::REC_KEY]);

   always_comb begin
      upd = grp_ff;
      upd[sgba_pkg::REC_CNT] = (grp_ff[sgba_pkg::REC_CNT] < SMAX) ?
                               grp_ff[sgba_pkg::REC_CNT] + 1'b1 : grp_ff[sgba_pkg::REC_CNT];
      upd[sgba_pkg::REC_HSUM] = grp_ff[sgba_pkg::REC_HSUM] + row_hv;
      upd[sgba_pkg::REC_RSUM] = grp_ff[sgba_pkg::REC_RSUM] + row_rv;
      if ($signed(row_hv) > $signed(grp_ff[sgba_pkg::REC_HMAX])) begin
         upd[sgba_pkg::REC_HMAX] = row_hv;
      end
      if ($signed(row_hv) < $signed(grp_ff[sgba_pkg::REC_HMIN])) begin
         upd[sgba_pkg::REC_HMIN] = row_hv;
      end
      if ($signed(row_rv) > $signed(grp_ff[sgba_pkg::REC_RMAX])) begin
         upd[sgba_pkg::REC_RMAX] = row_rv;
      end
      if ($signed(row_rv) < $signed(grp_ff[sgba_pkg::REC_RMIN])) begin
         upd[sgba_pkg::REC_RMIN] = row_rv;
      end
   end

   always_comb begin
      opn[sgba_pkg::REC_KEY]  = row_key;
      opn[sgba_pkg::REC_CNT]  = DATA_WIDTH'(1);
      opn[sgba_pkg::REC_HSUM] = row_hv;
      opn[sgba_pkg::REC_HMAX] = row_hv;
      opn[sgba_pkg::REC_HMIN] = row_hv;
      opn[sgba_pkg::REC_RSUM] = row_rv;
      opn[sgba_pkg::REC_RMAX] = row_rv;
      opn[sgba_pkg::REC_RMIN] = row_rv;
   end

   always_comb begin
      started_in    = started_ff;
      close_pend_in = close_pend_ff;
      grp_in        = grp_ff;
      push          = 1'b0;
      push_rec      = {1'b1, grp_ff};
      if (fire) begin
         if (!started_ff || same) begin
            grp_in     = same ? upd : opn;
            started_in = !row_last;
            push       = row_last;
            push_rec   = {1'b1, grp_in};
         end else begin
            // key changed: close the old group now; with row_last the new
            // one-row group is held pending and closes once the queue has room
            push          = 1'b1;
            push_rec      = {!row_last, grp_ff};
            grp_in        = opn;
            started_in    = 1'b1;
            close_pend_in = row_last;
         end
      end else if (close_pend_ff && !q_full) begin
         push          = 1'b1;
         push_rec      = {1'b1, grp_ff};
         started_in    = 1'b0;
         close_pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff    <= 1'b0;
         close_pend_ff <= 1'b0;
      end else begin
         started_ff    <= started_in;
         close_pend_ff <= close_pend_in;
      end
      grp_ff <= grp_in;
   end

   a_pend_blocks_rows: assert property (@(posedge clock) disable iff (reset)
      close_pend_ff |-> !row_ready)
      else $error("row accepted while a trailing group close is pending");

   a_pend_has_group: assert property (@(posedge clock) disable iff (reset)
      close_pend_ff |-> started_ff)
      else $error("trailing close pending with no open group");

endmodule

FILE: rtl/sgba_queue.sv
// Small register FIFO that carries closed-group records from front to back.
// Uses sgba_pkg for its default depth; width and depth come from the instantiating module.
module sgba_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = sgba_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full      = (cnt_ff == CW'(DEPTH));
   assign pop_valid = (cnt_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("record pushed into a full queue");

endmodule

FILE: rtl/sgba_div.sv
// Signed-by-positive radix-2 restoring divider, one quotient bit per cycle,
// truncating toward zero. Uses sgba_pkg for its default width; used by sgba_back for AVG.
module sgba_div #(
   parameter int DATA_WIDTH = sgba_pkg::DATA_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DATA_WIDTH-1:0] dividend,
   input  logic [DATA_WIDTH-1:0] divisor,
   output logic                  done,
   output logic [DATA_WIDTH-1:0] quotient
);

   localparam int W  = DATA_WIDTH;
   localparam int CW = $clog2(W);

   logic          busy_ff, busy_in, done_ff, done_in, neg_ff, neg_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  rem_ff, rem_in, quo_ff, quo_in, dsr_ff, dsr_in;
   logic [W:0]    trial, diff;
   logic          ge;

   assign trial    = {rem_ff, quo_ff[W-1]};
   assign diff     = trial - {1'b0, dsr_ff};
   assign ge       = trial >= {1'b0, dsr_ff};
   assign done     = done_ff;
   assign quotient = neg_ff ? (W'(0) - quo_ff) : quo_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in  = dividend[W-1];
         quo_in  = dividend[W-1] ? (W'(0) - dividend) : dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CW'(W - 1);
      end else if (busy_ff) begin
         rem_in = ge ? diff[W-1:0] : trial[W-1:0];
         quo_in = {quo_ff[W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

endmodule

FILE: rtl/sgba_back.sv
// Back end: pops closed-group records, evaluates the having aggregate and test,
// computes the return aggregate and drives the result register. Uses sgba_pkg, sgba_div.
module sgba_back #(
   parameter int DATA_WIDTH = sgba_pkg::DATA_WIDTH_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  sgba_pkg::cfg_type                        cfg,
   input  logic [DATA_WIDTH-1:0]                    threshold,
   input  logic                                     q_valid,
   input  logic [sgba_pkg::REC_FIELDS*DATA_WIDTH:0] q_data,
   output logic                                     q_pop,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic [DATA_WIDTH-1:0]                    rsp_key,
   output logic [DATA_WIDTH-1:0]                    rsp_val,
   output logic                                     rsp_last
);

   localparam int W     = DATA_WIDTH;
   localparam int F     = sgba_pkg::REC_FIELDS;
   localparam int REC_W = F * W + 1;

   sgba_pkg::back_state_type state_ff, state_in;

   logic [REC_W-1:0] rec_ff, rec_in;
   logic [F-1:0][W-1:0] rec_g, head_g;
   logic [W-1:0] hval_ff, hval_in, rval_ff, rval_in;
   logic         pass_ff, pass_in;
   logic         pend_valid_ff, pend_valid_in;
   logic [W-1:0] pend_key_ff, pend_key_in, pend_val_ff, pend_val_in;
   logic         rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [W-1:0] rsp_key_ff, rsp_key_in, rsp_val_ff, rsp_val_in;
   logic         out_free, rec_end;
   logic         div_start, div_done;
   logic [W-1:0] div_dvd, div_dsr, div_q;

   assign rec_g   = rec_ff[F*W-1:0];
   assign head_g  = q_data[F*W-1:0];
   assign rec_end = rec_ff[F*W];
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_key   = rsp_key_ff;
   assign rsp_val   = rsp_val_ff;
   assign rsp_last  = rsp_last_ff;

   function automatic logic [W-1:0] agg_pick(logic [sgba_pkg::FUNC_W-1:0] fn,
                                             logic [W-1:0] cnt, logic [W-1:0] sum,
                                             logic [W-1:0] mx, logic [W-1:0] mn);
      case (fn)
         sgba_pkg::FN_SUM:   return sum;
         sgba_pkg::FN_MAX:   return mx;
         sgba_pkg::FN_MIN:   return mn;
         sgba_pkg::FN_COUNT: return cnt;
         default:            return '0;
      endcase
   endfunction

   function automatic logic having_test(logic [sgba_pkg::FUNC_W-1:0] op,
                                        logic [W-1:0] a, logic [W-1:0] t);
      logic lt, gt;
      lt = $signed(a) < $signed(t);
      gt = $signed(a) > $signed(t);
      case (op)
         sgba_pkg::OP_LT: return lt;
         sgba_pkg::OP_GT: return gt;
         sgba_pkg::OP_LE: return !gt;
         sgba_pkg::OP_GE: return !lt;
         sgba_pkg::OP_EQ: return a == t;
         sgba_pkg::OP_NE: return a != t;
         default:         return 1'b0;
      endcase
   endfunction

   sgba_div #(
      .DATA_WIDTH (W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dsr),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      state_in      = state_ff;
      rec_in        = rec_ff;
      hval_in       = hval_ff;
      rval_in       = rval_ff;
      pass_in       = pass_ff;
      pend_valid_in = pend_valid_ff;
      pend_key_in   = pend_key_ff;
      pend_val_in   = pend_val_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_key_in    = rsp_key_ff;
      rsp_val_in    = rsp_val_ff;
      rsp_last_in   = rsp_last_ff;
      q_pop         = 1'b0;
      div_start     = 1'b0;
      div_dvd       = rec_g[sgba_pkg::REC_RSUM];
      div_dsr       = rec_g[sgba_pkg::REC_CNT];

      case (state_ff)
         sgba_pkg::BK_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               rec_in = q_data;
               if (cfg.having_func == sgba_pkg::FN_AVG) begin
                  div_start = 1'b1;
                  div_dvd   = head_g[sgba_pkg::REC_HSUM];
                  div_dsr   = head_g[sgba_pkg::REC_CNT];
                  state_in  = sgba_pkg::BK_HDIV;
               end else begin
                  hval_in  = agg_pick(cfg.having_func, head_g[sgba_pkg::REC_CNT],
                                      head_g[sgba_pkg::REC_HSUM], head_g[sgba_pkg::REC_HMAX],
                                      head_g[sgba_pkg::REC_HMIN]);
                  state_in = sgba_pkg::BK_TEST;
               end
            end
         end
         sgba_pkg::BK_HDIV: begin
            if (div_done) begin
               hval_in  = div_q;
               state_in = sgba_pkg::BK_TEST;
            end
         end
         sgba_pkg::BK_TEST: begin
            pass_in = having_test(cfg.having_op, hval_ff, threshold);
            if (pass_in && cfg.return_func == sgba_pkg::FN_AVG) begin
               div_start = 1'b1;
               state_in  = sgba_pkg::BK_RDIV;
            end else begin
               rval_in  = agg_pick(cfg.return_func, rec_g[sgba_pkg::REC_CNT],
                                   rec_g[sgba_pkg::REC_RSUM], rec_g[sgba_pkg::REC_RMAX],
                                   rec_g[sgba_pkg::REC_RMIN]);
               state_in = sgba_pkg::BK_OUT;
            end
         end
         sgba_pkg::BK_RDIV: begin
            if (div_done) begin
               rval_in  = div_q;
               state_in = sgba_pkg::BK_OUT;
            end
         end
         sgba_pkg::BK_OUT: begin
            if (!pend_valid_ff) begin
               if (pass_ff && !rec_end) begin
                  // another close from the same row follows: hold this
                  // result until it is known whether it is the row's last
                  pend_valid_in = 1'b1;
                  pend_key_in   = rec_g[sgba_pkg::REC_KEY];
                  pend_val_in   = rval_ff;
                  state_in      = sgba_pkg::BK_IDLE;
               end else if (pass_ff) begin
                  if (out_free) begin
                     rsp_valid_in = 1'b1;
                     rsp_key_in   = rec_g[sgba_pkg::REC_KEY];
                     rsp_val_in   = rval_ff;
                     rsp_last_in  = 1'b1;
                     state_in     = sgba_pkg::BK_IDLE;
                  end
               end else begin
                  state_in = sgba_pkg::BK_IDLE;
               end
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_key_in    = pend_key_ff;
               rsp_val_in    = pend_val_ff;
               rsp_last_in   = !pass_ff;
               pend_valid_in = 1'b0;
               state_in      = pass_ff ? sgba_pkg::BK_OUT2 : sgba_pkg::BK_IDLE;
            end
         end
         sgba_pkg::BK_OUT2: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_key_in   = rec_g[sgba_pkg::REC_KEY];
               rsp_val_in   = rval_ff;
               rsp_last_in  = 1'b1;
               state_in     = sgba_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = sgba_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sgba_pkg::BK_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rec_ff      <= rec_in;
      hval_ff     <= hval_in;
      rval_ff     <= rval_in;
      pass_ff     <= pass_in;
      pend_key_ff <= pend_key_in;
      pend_val_ff <= pend_val_in;
      rsp_key_ff  <= rsp_key_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_last_ff <= rsp_last_in;
   end

   a_pend_before_row_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sgba_pkg::BK_OUT && pend_valid_ff) |-> rec_end)
      else $error("held result met a record that does not end its row");

   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == sgba_pkg::BK_HDIV || state_ff == sgba_pkg::BK_RDIV))
      else $error("divider finished outside a divide state");

endmodule

FILE: rtl/sorted_groupby_having_aggregator_core.sv
// Top level of the sorted group-by aggregator with having filter.
// Holds the configuration registers; instantiates sgba_front, sgba_queue, sgba_back.
//
// Usage:
//  - req_* carries rows sorted by group key, one beat per row; req_tlast marks
//    the last row of the stream. rsp_* carries one beat per group that passes
//    the having test; rsp_tlast marks the final result caused by an input row.
//  - csr_* writes registers 0 having_func, 1 having_op, 2 threshold,
//    3 return_func; write only while the block is idle.
//  - Throughput: the front accepts one row per cycle while the queue has room; a row
//    that changes the key and also carries tlast blocks the next row until its second
//    close is pushed. The back end takes one closed group at a time, and every AVG it
//    evaluates runs through one radix-2 divider, one quotient bit per cycle. A queue of
//    QUEUE_DEPTH records absorbs bursts of group closes.
//  - Reset clears the open group, the queue, the pending result and restores
//    the register defaults (sum, lt, 0, sum).
//  - When rsp_tready is low, the result register holds, the back end waits,
//    the queue fills and req_tready drops.
module sorted_groupby_having_aggregator_core #(
   parameter int DATA_WIDTH  = sgba_pkg::DATA_WIDTH_DEF,
   parameter int QUEUE_DEPTH = sgba_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // group_key [31:0], having_value [63:32], return_value [95:64]
   input  logic [sgba_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // out_key [31:0], agg_value [63:32]
   output logic [sgba_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic [sgba_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [sgba_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int W     = DATA_WIDTH;
   localparam int FW    = sgba_pkg::FIELD_W;
   localparam int REC_W = sgba_pkg::REC_FIELDS * W + 1;

   sgba_pkg::cfg_type cfg_ff, cfg_in;
   logic [W-1:0]      thr_ff, thr_in;

   logic [W-1:0]       row_key, row_hv, row_rv;
   logic               push, q_full, q_pop, q_valid;
   logic [REC_W-1:0]   push_rec, q_data;
   logic [W-1:0]       out_key, out_val;

   // fields arrive as signed 32-bit values; resize to the internal width
   assign row_key = W'(signed'(req_tdata[FW-1:0]));
   assign row_hv  = W'(signed'(req_tdata[2*FW-1:FW]));
   assign row_rv  = W'(signed'(req_tdata[3*FW-1:2*FW]));

   assign rsp_tdata = {FW'(signed'(out_val)), FW'(signed'(out_key))};

   always_comb begin
      cfg_in = cfg_ff;
      thr_in = thr_ff;
      if (csr_we) begin
         case (csr_addr)
            sgba_pkg::CSR_HAVING_FUNC: cfg_in.having_func = csr_wdata[sgba_pkg::FUNC_W-1:0];
            sgba_pkg::CSR_HAVING_OP:   cfg_in.having_op   = csr_wdata[sgba_pkg::FUNC_W-1:0];
            sgba_pkg::CSR_THRESHOLD:   thr_in             = W'(signed'(csr_wdata));
            sgba_pkg::CSR_RETURN_FUNC: cfg_in.return_func = csr_wdata[sgba_pkg::FUNC_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.having_func <= sgba_pkg::FN_SUM;
         cfg_ff.having_op   <= sgba_pkg::OP_LT;
         cfg_ff.return_func <= sgba_pkg::FN_SUM;
         thr_ff             <= '0;
      end else begin
         cfg_ff <= cfg_in;
         thr_ff <= thr_in;
      end
   end

   sgba_front #(
      .DATA_WIDTH (W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .row_valid (req_tvalid),
      .row_ready (req_tready),
      .row_key   (row_key),
      .row_hv    (row_hv),
      .row_rv    (row_rv),
      .row_last  (req_tlast),
      .push      (push),
      .push_rec  (push_rec),
      .q_full    (q_full)
   );

   sgba_queue #(
      .WIDTH (REC_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_rec),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_data)
   );

   sgba_back #(
      .DATA_WIDTH (W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .threshold (thr_ff),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_key   (out_key),
      .rsp_val   (out_val),
      .rsp_last  (rsp_tlast)
   );

endmodule

FILE: bench/tb_sorted_groupby_having_aggregator_core.sv
// Testbench for sorted_groupby_having_aggregator_core: drives sorted row streams,
// predicts each passing group and its aggregate, and checks every result beat.
// Depends on rtl/sgba_pkg.sv and the core RTL only.
`timescale 1ns / 100ps

module tb_sorted_groupby_having_aggregator_core;

   typedef logic [sgba_pkg::FUNC_W-1:0] code_type;

   // function and operator codes the block treats as "none"
   localparam code_type FN_NONE    = 3'd5;
   localparam code_type FN_NONE_HI = 3'd7;
   localparam code_type OP_NONE    = 3'd6;
   localparam code_type OP_NONE_HI = 3'd7;

   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   // every queued record may need two AVG divisions on top of its other back-end steps
   localparam int DRAIN_CYCLES    = (sgba_pkg::QUEUE_DEPTH_DEF + 2) *
                                    (3 + 2 * (sgba_pkg::DATA_WIDTH_DEF + 1));
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int WATCHDOG_LIMIT  = 20000;

   typedef struct packed {
      logic signed [31:0] key;
      logic signed [31:0] value;
      logic               last;
   } group_result_type;

   logic                             clock;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   // group_key [31:0], having_value [63:32], return_value [95:64]
   logic [sgba_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                             req_tlast  = 1'b0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   // out_key [31:0], agg_value [63:32]
   logic [sgba_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                             rsp_tlast;
   logic                             csr_we     = 1'b0;
   logic [sgba_pkg::CSR_ADDR_W-1:0]  csr_addr   = '0;
   logic [sgba_pkg::CSR_DATA_W-1:0]  csr_wdata  = '0;

   sorted_groupby_having_aggregator_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // register copy
   code_type           cfg_having_func = sgba_pkg::FN_SUM;
   code_type           cfg_having_op   = sgba_pkg::OP_LT;
   logic signed [31:0] cfg_threshold   = '0;
   code_type           cfg_return_func = sgba_pkg::FN_SUM;

   // open group
   logic               grp_open  = 1'b0;
   logic signed [31:0] grp_key   = '0;
   logic [31:0]        grp_count = '0;
   logic signed [31:0] hv_sum = '0, hv_max = '0, hv_min = '0;
   logic signed [31:0] rv_sum = '0, rv_max = '0, rv_min = '0;

   group_result_type group_results_due[$];

   bit tx_gaps_on    = 1'b1;
   bit rx_gaps_on    = 1'b1;
   int hold_requests = 0;
   int holds_served  = 0;
   int hold_left     = 0;
   int rows_sent     = 0;
   int results_seen  = 0;
   int settings_used = 0;
   int mismatches    = 0;

   function automatic logic signed [31:0] group_aggregate(code_type fn,
                                                          logic signed [31:0] sum,
                                                          logic signed [31:0] mx,
                                                          logic signed [31:0] mn);
      logic [31:0] magnitude;
      logic [31:0] quotient;
      case (fn)
         sgba_pkg::FN_AVG: begin
            // divide the magnitude, then restore the sign: truncates toward zero
            magnitude = sum[31] ? -sum : sum;
            quotient  = magnitude / grp_count;
            return sum[31] ? -quotient : quotient;
         end
         sgba_pkg::FN_SUM:   return sum;
         sgba_pkg::FN_MAX:   return mx;
         sgba_pkg::FN_MIN:   return mn;
         sgba_pkg::FN_COUNT: return grp_count;
         default:            return '0;
      endcase
   endfunction

   function automatic bit having_passes(logic signed [31:0] agg);
      case (cfg_having_op)
         sgba_pkg::OP_LT: return agg < cfg_threshold;
         sgba_pkg::OP_GT: return agg > cfg_threshold;
         sgba_pkg::OP_LE: return agg <= cfg_threshold;
         sgba_pkg::OP_GE: return agg >= cfg_threshold;
         sgba_pkg::OP_EQ: return agg == cfg_threshold;
         sgba_pkg::OP_NE: return agg != cfg_threshold;
         default:         return 1'b0;
      endcase
   endfunction

   function automatic void open_group(logic signed [31:0] key, logic signed [31:0] hv,
                                      logic signed [31:0] rv);
      grp_open  = 1'b1;
      grp_key   = key;
      grp_count = 32'd1;
      hv_sum    = hv;
      hv_max    = hv;
      hv_min    = hv;
      rv_sum    = rv;
      rv_max    = rv;
      rv_min    = rv;
   endfunction

   function automatic bit close_group(output group_result_type res);
      logic signed [31:0] having_agg;
      having_agg = group_aggregate(cfg_having_func, hv_sum, hv_max, hv_min);
      grp_open   = 1'b0;
      res.key    = grp_key;
      res.value  = group_aggregate(cfg_return_func, rv_sum, rv_max, rv_min);
      res.last   = 1'b0;
      return having_passes(having_agg);
   endfunction

   function automatic void absorb_row(logic signed [31:0] key, logic signed [31:0] hv,
                                      logic signed [31:0] rv, logic last);
      group_result_type found[$];
      group_result_type res;
      if (!grp_open) begin
         open_group(key, hv, rv);
      end else if (key == grp_key) begin
         if (grp_count < 32'h7FFF_FFFF) grp_count++;
         hv_sum = hv_sum + hv;
         rv_sum = rv_sum + rv;
         if (hv > hv_max) hv_max = hv;
         if (hv < hv_min) hv_min = hv;
         if (rv > rv_max) rv_max = rv;
         if (rv < rv_min) rv_min = rv;
      end else begin
         if (close_group(res)) found.insert(found.size(), res);
         open_group(key, hv, rv);
      end
      if (last) begin
         if (close_group(res)) found.insert(found.size(), res);
      end
      foreach (found[i]) begin
         if (i == found.size() - 1) found[i].last = 1'b1;
         group_results_due.insert(group_results_due.size(), found[i]);
      end
   endfunction

   task automatic send_row(logic signed [31:0] key, logic signed [31:0] hv,
                           logic signed [31:0] rv, logic last);
      if (tx_gaps_on && $urandom_range(99) < 8) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {rv, hv, key};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      absorb_row(key, hv, rv, last);
      rows_sent++;
   endtask

   // drop valid, wait for every expected beat, then let the back end finish
   task automatic wait_until_idle();
      req_tvalid <= 1'b0;
      while (group_results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings(code_type hfn, code_type hop,
                                 logic signed [31:0] thr, code_type rfn);
      wait_until_idle();
      csr_we    <= 1'b1;
      csr_addr  <= sgba_pkg::CSR_HAVING_FUNC;
      csr_wdata <= 32'(hfn);
      @(posedge clock);
      csr_addr  <= sgba_pkg::CSR_HAVING_OP;
      csr_wdata <= 32'(hop);
      @(posedge clock);
      csr_addr  <= sgba_pkg::CSR_THRESHOLD;
      csr_wdata <= thr;
      @(posedge clock);
      csr_addr  <= sgba_pkg::CSR_RETURN_FUNC;
      csr_wdata <= 32'(rfn);
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_having_func = hfn;
      cfg_having_op   = hop;
      cfg_threshold   = thr;
      cfg_return_func = rfn;
      settings_used++;
   endtask

   function automatic logic signed [31:0] random_value();
      case ($urandom_range(11))
         0:       return $urandom;
         1:       return S32_MAX - $urandom_range(3);
         2:       return S32_MIN + $urandom_range(3);
         default: return int'($urandom_range(200)) - 100;
      endcase
   endfunction

   function automatic code_type random_func();
      if ($urandom_range(9) < 8) return code_type'($urandom_range(sgba_pkg::FN_COUNT));
      return code_type'($urandom_range(FN_NONE_HI));
   endfunction

   function automatic code_type random_op();
      if ($urandom_range(9) < 8) return code_type'($urandom_range(sgba_pkg::OP_NE));
      return code_type'($urandom_range(OP_NONE_HI));
   endfunction

   function automatic logic signed [31:0] random_threshold();
      case ($urandom_range(7))
         0:       return S32_MIN;
         1:       return S32_MAX;
         2:       return $urandom;
         3:       return '0;
         4:       return $urandom_range(4);
         default: return int'($urandom_range(100)) - 50;
      endcase
   endfunction

   // mostly ascending keys in groups of a few rows, with stray jumps and early row-ends
   task automatic send_sorted_rows(int n_rows);
      logic signed [31:0] key;
      int                 left_in_group;
      logic               last;
      key           = ($urandom_range(3) == 0) ? $urandom : int'($urandom_range(20)) - 10;
      left_in_group = 0;
      for (int i = 0; i < n_rows; i++) begin
         if (left_in_group == 0) begin
            left_in_group = $urandom_range(6, 1);
            case ($urandom_range(11))
               0:       key = $urandom;
               1:       key = key - $urandom_range(3, 1);
               default: key = key + $urandom_range(4, 1);
            endcase
         end
         left_in_group--;
         if (i == n_rows - 1) last = ($urandom_range(3) != 0);
         else if (left_in_group == 0) last = ($urandom_range(9) == 0);
         else last = ($urandom_range(29) == 0);
         send_row(key, random_value(), random_value(), last);
      end
   endtask

   task automatic test_reset_defaults();
      // register defaults: having sum below zero, return sum
      send_row(32'sd0, -32'sd1, S32_MAX, 1'b0);
      send_row(32'sd0, 32'sd0, 32'sd1, 1'b1);
   endtask

   task automatic test_sum_wrap_and_double_close();
      apply_settings(sgba_pkg::FN_SUM, sgba_pkg::OP_NE, 32'sd0, sgba_pkg::FN_SUM);
      send_row(S32_MIN, S32_MAX, S32_MAX, 1'b0);
      send_row(S32_MIN, 32'sd1, 32'sd1, 1'b0);
      // key change on the final row closes two groups
      send_row(S32_MAX, S32_MIN, S32_MIN, 1'b1);
   endtask

   task automatic test_avg_truncation_and_restart();
      apply_settings(sgba_pkg::FN_AVG, sgba_pkg::OP_GE, S32_MIN, sgba_pkg::FN_AVG);
      send_row(32'sd5, -32'sd7, 32'sd7, 1'b0);
      send_row(32'sd5, 32'sd0, 32'sd0, 1'b0);
      send_row(32'sd5, 32'sd0, 32'sd1, 1'b1);
      // new stream after the end, and keys out of order
      send_row(32'sd3, S32_MIN, S32_MIN, 1'b0);
      send_row(32'sd2, 32'sd1, -32'sd1, 1'b1);
   endtask

   task automatic test_max_min();
      apply_settings(sgba_pkg::FN_MAX, sgba_pkg::OP_LT, 32'sd10, sgba_pkg::FN_MIN);
      send_row(32'sd0, 32'sd9, 32'sd4, 1'b0);
      send_row(32'sd0, -32'sd3, S32_MIN, 1'b0);
      send_row(32'sd1, 32'sd10, S32_MAX, 1'b1);
      apply_settings(sgba_pkg::FN_MIN, sgba_pkg::OP_GT, -32'sd5, sgba_pkg::FN_MAX);
      send_row(32'sd7, -32'sd4, -32'sd1, 1'b0);
      send_row(32'sd7, 32'sd100, -32'sd9, 1'b0);
      send_row(32'sd8, -32'sd5, 32'sd0, 1'b1);
   endtask

   task automatic test_count_functions();
      apply_settings(sgba_pkg::FN_COUNT, sgba_pkg::OP_EQ, 32'sd2, sgba_pkg::FN_COUNT);
      send_row(32'sd1, 32'sd0, 32'sd0, 1'b0);
      send_row(32'sd1, 32'sd0, 32'sd0, 1'b0);
      send_row(32'sd2, 32'sd0, 32'sd0, 1'b1);
      apply_settings(sgba_pkg::FN_COUNT, sgba_pkg::OP_LE, 32'sd1, FN_NONE);
      send_row(32'sd4, 32'sd3, 32'sd3, 1'b0);
      send_row(32'sd5, 32'sd3, 32'sd3, 1'b1);
   endtask

   task automatic test_unused_codes();
      apply_settings(FN_NONE_HI - 3'd1, sgba_pkg::OP_EQ, 32'sd0, FN_NONE_HI);
      send_row(32'sd9, 32'sd6, 32'sd6, 1'b1);
      apply_settings(sgba_pkg::FN_SUM, OP_NONE, 32'sd0, sgba_pkg::FN_SUM);
      send_row(32'sd1, -32'sd1, 32'sd1, 1'b1);
      apply_settings(sgba_pkg::FN_SUM, OP_NONE_HI, 32'sd0, sgba_pkg::FN_SUM);
      send_row(32'sd1, -32'sd1, 32'sd1, 1'b1);
   endtask

   task automatic test_output_backpressure();
      // every group passes, so results pile up behind the held receiver
      apply_settings(sgba_pkg::FN_COUNT, sgba_pkg::OP_GE, 32'sd1, sgba_pkg::FN_AVG);
      hold_requests++;
      for (int i = 0; i < 40; i++) begin
         send_row(32'(i), random_value(), random_value(), i == 39);
      end
   endtask

   task automatic test_back_to_back();
      apply_settings(sgba_pkg::FN_SUM, sgba_pkg::OP_NE, 32'sd3, sgba_pkg::FN_MAX);
      tx_gaps_on = 1'b0;
      rx_gaps_on = 1'b0;
      send_sorted_rows(150);
      wait_until_idle();
      tx_gaps_on = 1'b1;
      rx_gaps_on = 1'b1;
   endtask

   task automatic test_random_streams(int n_phases);
      for (int p = 0; p < n_phases; p++) begin
         apply_settings(random_func(), random_op(), random_threshold(), random_func());
         send_sorted_rows($urandom_range(50, 20));
      end
   endtask

   // receiver: random stalls plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_requests != holds_served) begin
         rsp_tready   <= 1'b0;
         hold_left    <= RSP_HOLD_CYCLES;
         holds_served <= hold_requests;
      end else if (rx_gaps_on) begin
         rsp_tready <= ($urandom_range(99) >= 16);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      group_result_type due;
      logic signed [31:0] got_key;
      logic signed [31:0] got_value;
      got_key   = rsp_tdata[31:0];
      got_value = rsp_tdata[63:32];
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (group_results_due.size() == 0) begin
            $error("unexpected result beat: out_key %0d agg_value %0d", got_key, got_value);
            mismatches++;
         end else begin
            due = group_results_due.pop_front();
            if (got_key !== due.key) begin
               $error("out_key: expected %0d, got %0d", due.key, got_key);
               mismatches++;
            end
            if (got_value !== due.value) begin
               $error("agg_value: expected %0d, got %0d", due.value, got_value);
               mismatches++;
            end
            if (rsp_tlast !== due.last) begin
               $error("last_of_run: expected %0d, got %0d", due.last, rsp_tlast);
               mismatches++;
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_sum_wrap_and_double_close();
      test_avg_truncation_and_restart();
      test_max_min();
      test_count_functions();
      test_unused_codes();
      test_output_backpressure();
      test_back_to_back();
      test_random_streams(32);
      wait_until_idle();
      $display("rows sent: %0d, result beats checked: %0d, register settings: %0d",
               rows_sent, results_seen, settings_used);
      $display("covered all functions and operators, wrap, two-result rows and back-pressure");
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
